/* rtl/ipdd_pkg.sv */
// Shared types, constants and arithmetic helpers for the differential-drive PID block.
`default_nettype none

package ipdd_pkg;

  // Configuration register indexes on the write port.
  localparam logic [2:0] REG_SPEED_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_GAIN_P          = 3'd1;
  localparam logic [2:0] REG_GAIN_I          = 3'd2;
  localparam logic [2:0] REG_GAIN_D          = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_CUTOFF = 3'd4;

  localparam int unsigned REG_INDEX_W = 3;
  localparam int unsigned REG_DATA_W  = 17;

  // Reset value of the proportional gain register.
  localparam logic signed [15:0] GAIN_P_RESET = 16'sd2560;

  // Drive limit and line deadband around the center column.
  localparam logic signed [13:0] DRIVE_LIMIT   = 14'sd7000;
  localparam int unsigned        LINE_CENTER   = 64;
  localparam int unsigned        LINE_DEADBAND = 5;
  localparam logic [7:0]         LINE_LOW      = 8'(LINE_CENTER - LINE_DEADBAND);
  localparam logic [7:0]         LINE_HIGH     = 8'(LINE_CENTER + LINE_DEADBAND);

  // Live configuration of the controller.
  typedef struct packed {
    logic signed [15:0] speed_setpoint;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [16:0] integral_cutoff;
  } cfg_t;

  // Forward/reverse duty pairs for both motors.
  typedef struct packed {
    logic [13:0] left_forward_duty;
    logic [13:0] left_reverse_duty;
    logic [13:0] right_forward_duty;
    logic [13:0] right_reverse_duty;
  } duty_t;

  // Q8.8 product scaled back by 256, rounded toward zero.
  function automatic logic signed [25:0] q88_trunc(input logic signed [33:0] prod);
    logic signed [33:0] adj;
    adj = prod + (prod[33] ? 34'sd255 : 34'sd0);
    return 26'(adj >>> 8);
  endfunction

endpackage

`default_nettype wire

/* rtl/ipdd_if.sv */
// Valid/ready channel interfaces for the sample input and the duty result.
`default_nettype none

interface ipdd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_speed;
  logic [7:0]         line_position;
  logic               stop_request;
  logic signed [13:0] steer_offset;

  modport source (output valid, measured_speed, line_position, stop_request, steer_offset,
                  input ready);
  modport sink (input valid, measured_speed, line_position, stop_request, steer_offset,
                output ready);
endinterface

interface ipdd_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        left_forward_duty;
  logic [13:0]        left_reverse_duty;
  logic [13:0]        right_forward_duty;
  logic [13:0]        right_reverse_duty;
  logic signed [13:0] drive_level;

  modport source (output valid, left_forward_duty, left_reverse_duty, right_forward_duty,
                  right_reverse_duty, drive_level, input ready);
  modport sink (input valid, left_forward_duty, left_reverse_duty, right_forward_duty,
                right_reverse_duty, drive_level, output ready);
endinterface

`default_nettype wire

/* rtl/ipdd_pid_core.sv */
// Incremental PID update with its feedback state and the clamped drive level.
`default_nettype none

module ipdd_pid_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire ipdd_pkg::cfg_t     cfg,
  input  wire logic signed [15:0] measured_speed,
  output logic signed [13:0]      level
);

  logic signed [16:0] previous_error;
  logic signed [15:0] raw_last;
  logic signed [15:0] raw_before_last;

  logic signed [16:0] err;
  logic signed [17:0] err_delta;
  logic signed [16:0] raw_delta;
  logic signed [33:0] p_prod;
  logic signed [33:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [25:0] p_term;
  logic signed [25:0] i_term;
  logic signed [25:0] d_term;
  logic signed [27:0] raw_sum;
  logic signed [15:0] raw_next;

  // Error terms and the three gain products.
  always_comb begin
    err       = 17'(cfg.speed_setpoint) - 17'(measured_speed);
    err_delta = 18'(err) - 18'(previous_error);
    raw_delta = 17'(raw_before_last) - 17'(raw_last);
    p_prod    = 34'(cfg.gain_p) * 34'(err_delta);
    i_prod    = 34'(cfg.gain_i) * 34'(err);
    d_prod    = 34'(cfg.gain_d) * 34'(raw_delta);
  end

  // Scale each product, skip the integral above the cutoff, and accumulate.
  always_comb begin
    p_term  = ipdd_pkg::q88_trunc(p_prod);
    i_term  = (err > cfg.integral_cutoff) ? 26'sd0 : ipdd_pkg::q88_trunc(i_prod);
    d_term  = ipdd_pkg::q88_trunc(d_prod);
    raw_sum = 28'(raw_last) + 28'(p_term) + 28'(i_term) + 28'(d_term);
  end

  // Saturate to 16 bits, then clamp to the drive limit.
  always_comb begin
    if (raw_sum > 28'sd32767) begin
      raw_next = 16'sh7FFF;
    end else if (raw_sum < -28'sd32768) begin
      raw_next = 16'sh8000;
    end else begin
      raw_next = 16'(raw_sum);
    end
    if (raw_next > 16'(ipdd_pkg::DRIVE_LIMIT)) begin
      level = ipdd_pkg::DRIVE_LIMIT;
    end else if (raw_next < -16'(ipdd_pkg::DRIVE_LIMIT)) begin
      level = -ipdd_pkg::DRIVE_LIMIT;
    end else begin
      level = 14'(raw_next);
    end
  end

  // Feedback state moves on with each processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error  <= '0;
      raw_last        <= '0;
      raw_before_last <= '0;
    end else if (step) begin
      previous_error  <= err;
      raw_last        <= raw_next;
      raw_before_last <= raw_last;
    end
  end

  // The output history shifts by one place per update.
  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    step |=> raw_before_last == $past(raw_last))
    else $error("raw output history did not shift");

  // State holds while no transaction is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(raw_last) && $stable(previous_error))
    else $error("PID state changed without a transaction");

endmodule

`default_nettype wire

/* rtl/ipdd_drive_mix.sv */
// Steering offset gating and mapping of both motor drives to PWM duty pairs.
`default_nettype none

module ipdd_drive_mix (
  input  wire logic signed [13:0] level,
  input  wire logic [7:0]         line_position,
  input  wire logic               stop_request,
  input  wire logic signed [13:0] steer_offset,
  output ipdd_pkg::duty_t         duty
);

  logic signed [13:0] offset_sat;
  logic signed [13:0] steer;
  logic signed [14:0] left_drive;
  logic signed [14:0] right_drive;
  logic signed [14:0] left_neg;
  logic signed [14:0] right_neg;

  // Limit the offset and apply it only off center and with no stop pending.
  always_comb begin
    if (steer_offset > ipdd_pkg::DRIVE_LIMIT) begin
      offset_sat = ipdd_pkg::DRIVE_LIMIT;
    end else if (steer_offset < -ipdd_pkg::DRIVE_LIMIT) begin
      offset_sat = -ipdd_pkg::DRIVE_LIMIT;
    end else begin
      offset_sat = steer_offset;
    end
    if (!stop_request && (line_position < ipdd_pkg::LINE_LOW ||
                          line_position > ipdd_pkg::LINE_HIGH)) begin
      steer = offset_sat;
    end else begin
      steer = '0;
    end
  end

  // Differential drives and their forward/reverse split.
  always_comb begin
    left_drive  = 15'(level) - 15'(steer);
    right_drive = 15'(level) + 15'(steer);
    left_neg    = -left_drive;
    right_neg   = -right_drive;
    duty.left_forward_duty  = left_drive[14]  ? 14'd0 : left_drive[13:0];
    duty.left_reverse_duty  = left_drive[14]  ? left_neg[13:0] : 14'd0;
    duty.right_forward_duty = right_drive[14] ? 14'd0 : right_drive[13:0];
    duty.right_reverse_duty = right_drive[14] ? right_neg[13:0] : 14'd0;
  end

endmodule

`default_nettype wire

/* rtl/incremental_pid_differential_drive.sv */
// Top level of the incremental PID speed controller with differential drive outputs.
// Usage: each transaction on the sample channel carries a measured speed, a line
// position, a stop request and a steering offset. For each one the block runs one
// incremental PID update against the configured setpoint and gains and returns one
// transaction on the result channel: forward/reverse PWM duties for the left and
// right motors and the clamped common drive level.
// The sample lands in the input register at the accepting edge; the PID update and drive
// mix settle into the result register when it is free or drains. Throughput is one
// transaction per cycle while the result side does not stall, set by the feedback update.
// A stalled result register holds its transaction; the input register still takes
// one more sample, after which sample.ready drops until the result is taken.
// Reset empties both pipeline registers, clears the PID history and loads the register
// defaults (proportional gain 10.0, all else zero). Configuration is written through
// wr_en/wr_index/wr_data; the user must write it only while no transaction is in flight,
// which the block itself does not enforce; unknown indexes are ignored.
`default_nettype none

module incremental_pid_differential_drive (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [ipdd_pkg::REG_INDEX_W-1:0]    wr_index,
  input  wire logic [ipdd_pkg::REG_DATA_W-1:0]     wr_data,
  ipdd_in_if.sink                                  sample,
  ipdd_out_if.source                               result
);

  ipdd_pkg::cfg_t     cfg;

  logic               in_valid;
  logic signed [15:0] in_speed;
  logic [7:0]         in_position;
  logic               in_stop;
  logic signed [13:0] in_offset;
  logic               advance;

  logic signed [13:0] level;
  ipdd_pkg::duty_t    duty;

  logic               out_valid;
  ipdd_pkg::duty_t    out_duty;
  logic signed [13:0] out_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_setpoint  <= '0;
      cfg.gain_p          <= ipdd_pkg::GAIN_P_RESET;
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.integral_cutoff <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        ipdd_pkg::REG_SPEED_SETPOINT:  cfg.speed_setpoint  <= wr_data[15:0];
        ipdd_pkg::REG_GAIN_P:          cfg.gain_p          <= wr_data[15:0];
        ipdd_pkg::REG_GAIN_I:          cfg.gain_i          <= wr_data[15:0];
        ipdd_pkg::REG_GAIN_D:          cfg.gain_d          <= wr_data[15:0];
        ipdd_pkg::REG_INTEGRAL_CUTOFF: cfg.integral_cutoff <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register advances whenever the result register is free or drains.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_speed    <= sample.measured_speed;
      in_position <= sample.line_position;
      in_stop     <= sample.stop_request;
      in_offset   <= sample.steer_offset;
    end
  end

  ipdd_pid_core u_pid_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .cfg            (cfg),
    .measured_speed (in_speed),
    .level          (level)
  );

  ipdd_drive_mix u_drive_mix (
    .level         (level),
    .line_position (in_position),
    .stop_request  (in_stop),
    .steer_offset  (in_offset),
    .duty          (duty)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty  <= duty;
      out_level <= level;
    end
  end

  assign result.valid              = out_valid;
  assign result.left_forward_duty  = out_duty.left_forward_duty;
  assign result.left_reverse_duty  = out_duty.left_reverse_duty;
  assign result.right_forward_duty = out_duty.right_forward_duty;
  assign result.right_reverse_duty = out_duty.right_reverse_duty;
  assign result.drive_level        = out_level;

  // A processed transaction always shows up in the result register.
  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction missing from result register");

  // The common drive level stays within the drive limit.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level <= ipdd_pkg::DRIVE_LIMIT &&
                   out_level >= -ipdd_pkg::DRIVE_LIMIT))
    else $error("drive level outside limit");

  // A motor never gets forward and reverse duty at once.
  a_duty_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_duty.left_forward_duty == 14'd0 ||
                   out_duty.left_reverse_duty == 14'd0) &&
                  (out_duty.right_forward_duty == 14'd0 ||
                   out_duty.right_reverse_duty == 14'd0))
    else $error("forward and reverse duty both active");

  // Nothing is taken into a full input register unless it moves on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> !sample.ready)
    else $error("input register would be overwritten");

endmodule

`default_nettype wire

/* bench/drive_scoreboard_pkg.sv */
// Predictor and scoreboard for the differential-drive PID testbench.
package drive_scoreboard_pkg;
  import ipdd_pkg::*;

  // One sample transaction as the testbench drives it.
  typedef struct packed {
    logic signed [15:0] measured_speed;
    logic [7:0]         line_position;
    logic               stop_request;
    logic signed [13:0] steer_offset;
  } speed_sample_t;

  // One result transaction: both duty pairs and the common drive level.
  typedef struct packed {
    duty_t              duties;
    logic signed [13:0] drive_level;
  } drive_result_t;

  localparam int MAX_REPORTED = 10;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Splits a signed drive into a forward/reverse duty pair.
  function automatic void split_drive(longint drive, output logic [13:0] fwd,
                                      output logic [13:0] rev);
    if (drive >= 0) begin
      fwd = 14'(drive);
      rev = '0;
    end else begin
      fwd = '0;
      rev = 14'(-drive);
    end
  endfunction

  class drive_scoreboard;
    cfg_t               cfg;
    logic signed [16:0] previous_error;
    logic signed [15:0] raw_last;
    logic signed [15:0] raw_before_last;
    drive_result_t      expected_drives[$];
    int                 failures;

    function new();
      cfg.speed_setpoint  = '0;
      cfg.gain_p          = GAIN_P_RESET;
      cfg.gain_i          = '0;
      cfg.gain_d          = '0;
      cfg.integral_cutoff = '0;
      previous_error      = '0;
      raw_last            = '0;
      raw_before_last     = '0;
      failures            = 0;
    endfunction

    // Mirrors a register write; unknown indexes leave everything as it was.
    function void set_register(logic [REG_INDEX_W-1:0] index, logic [REG_DATA_W-1:0] data);
      case (index)
        REG_SPEED_SETPOINT:  cfg.speed_setpoint = data[15:0];
        REG_GAIN_P:          cfg.gain_p = data[15:0];
        REG_GAIN_I:          cfg.gain_i = data[15:0];
        REG_GAIN_D:          cfg.gain_d = data[15:0];
        REG_INTEGRAL_CUTOFF: cfg.integral_cutoff = data;
        default: ;
      endcase
    endfunction

    // Runs one incremental PID update and queues the duties it should produce.
    function void note_sample(speed_sample_t s);
      longint        error;
      longint        increment;
      longint        raw;
      longint        level;
      longint        offset;
      longint        distance;
      longint        drive_max;
      drive_result_t r;
      drive_max = longint'(DRIVE_LIMIT);
      error = longint'(cfg.speed_setpoint) - longint'(s.measured_speed);
      // Each Q8.8 product is scaled back on its own, rounding toward zero.
      increment = longint'(cfg.gain_p) * (error - longint'(previous_error)) / 256;
      if (!(error > longint'(cfg.integral_cutoff)))
        increment += longint'(cfg.gain_i) * error / 256;
      increment += longint'(cfg.gain_d) * (longint'(raw_before_last) - longint'(raw_last)) / 256;
      raw = clip(longint'(raw_last) + increment, -32768, 32767);
      previous_error  = 17'(error);
      raw_before_last = raw_last;
      raw_last        = 16'(raw);
      level = clip(raw, -drive_max, drive_max);
      // Steering applies only off center and without a stop request.
      distance = longint'(s.line_position) - longint'(LINE_CENTER);
      if (distance < 0) distance = -distance;
      offset = 0;
      if (!s.stop_request && distance > longint'(LINE_DEADBAND))
        offset = clip(longint'(s.steer_offset), -drive_max, drive_max);
      split_drive(level - offset, r.duties.left_forward_duty, r.duties.left_reverse_duty);
      split_drive(level + offset, r.duties.right_forward_duty, r.duties.right_reverse_duty);
      r.drive_level = 14'(level);
      expected_drives.push_back(r);
    endfunction

    // Compares a result with the oldest expected one.
    function void check_result(drive_result_t seen);
      drive_result_t want;
      logic          bad;
      if (expected_drives.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTED)
          $display("%0t: result with no sample outstanding: lf=%0d lr=%0d rf=%0d rr=%0d lvl=%0d",
                   $realtime, seen.duties.left_forward_duty, seen.duties.left_reverse_duty,
                   seen.duties.right_forward_duty, seen.duties.right_reverse_duty,
                   seen.drive_level);
        return;
      end
      want = expected_drives.pop_front();
      bad = (seen.duties.left_forward_duty !== want.duties.left_forward_duty)
         || (seen.duties.left_reverse_duty !== want.duties.left_reverse_duty)
         || (seen.duties.right_forward_duty !== want.duties.right_forward_duty)
         || (seen.duties.right_reverse_duty !== want.duties.right_reverse_duty)
         || (seen.drive_level !== want.drive_level);
      if (bad) begin
        failures++;
        if (failures <= MAX_REPORTED)
          $display("%0t: drive mismatch: expected lf=%0d lr=%0d rf=%0d rr=%0d lvl=%0d, got lf=%0d lr=%0d rf=%0d rr=%0d lvl=%0d",
                   $realtime, want.duties.left_forward_duty, want.duties.left_reverse_duty,
                   want.duties.right_forward_duty, want.duties.right_reverse_duty,
                   want.drive_level, seen.duties.left_forward_duty,
                   seen.duties.left_reverse_duty, seen.duties.right_forward_duty,
                   seen.duties.right_reverse_duty, seen.drive_level);
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

endpackage

/* bench/incremental_pid_differential_drive_tb.sv */
// Top-level testbench for the incremental PID differential-drive block.
module incremental_pid_differential_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipdd_pkg::*;
  import drive_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 115;
  localparam int PHASES       = 6;
  // First register index that has no register behind it.
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LOW = 3'd5;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   wr_en = 1'b0;
  logic [REG_INDEX_W-1:0] wr_index = '0;
  logic [REG_DATA_W-1:0]  wr_data = '0;

  int              cycle_count = 0;
  int              burst_left = 0;
  logic [15:0]     stall_pattern = '1;
  int              pattern_left = 0;
  drive_result_t   seen_result;
  drive_scoreboard sb = new;

  ipdd_in_if  sample_ch ();
  ipdd_out_if result_ch ();

  incremental_pid_differential_drive u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sample   (sample_ch),
    .result   (result_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then stall on a rotating pattern.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen_result.duties.left_forward_duty  = result_ch.left_forward_duty;
      seen_result.duties.left_reverse_duty  = result_ch.left_reverse_duty;
      seen_result.duties.right_forward_duty = result_ch.right_forward_duty;
      seen_result.duties.right_reverse_duty = result_ch.right_reverse_duty;
      seen_result.drive_level               = result_ch.drive_level;
      sb.check_result(seen_result);
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(60, 10);
      if ($urandom_range(3, 0) == 0)
        stall_pattern = '1;
      else
        stall_pattern = 16'($urandom) | 16'h0101;
    end else begin
      pattern_left--;
    end
    stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
    result_ch.ready <= stall_pattern[0];
  end

  // Presents one sample and holds it until the block takes it.
  task automatic send_sample(speed_sample_t s);
    sample_ch.valid          <= 1'b1;
    sample_ch.measured_speed <= s.measured_speed;
    sample_ch.line_position  <= s.line_position;
    sample_ch.stop_request   <= s.stop_request;
    sample_ch.steer_offset   <= s.steer_offset;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Sender idles between bursts of back-to-back transactions.
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1);
      gap = $urandom_range(10, 1);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every expected result has come back.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [REG_INDEX_W-1:0] index, logic [REG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(posedge clk);
    sb.set_register(index, data);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Loads a full setting while idle, plus one write to an unused index.
  task automatic apply_settings(cfg_t c);
    drain();
    write_register(REG_SPEED_SETPOINT, 17'(c.speed_setpoint));
    write_register(REG_GAIN_P, 17'(c.gain_p));
    write_register(REG_GAIN_I, 17'(c.gain_i));
    write_register(REG_GAIN_D, 17'(c.gain_d));
    write_register(REG_INTEGRAL_CUTOFF, c.integral_cutoff);
    write_register(REG_INDEX_W'($urandom_range(2 ** REG_INDEX_W - 1, REG_SPARE_LOW)),
                   REG_DATA_W'($urandom));
  endtask

  function automatic speed_sample_t make_sample(int speed, int position, bit stop, int steer);
    speed_sample_t s;
    s.measured_speed = 16'(speed);
    s.line_position  = 8'(position);
    s.stop_request   = stop;
    s.steer_offset   = 14'(steer);
    return s;
  endfunction

  // Speeds mostly track the setpoint so the loop stays out of saturation.
  function automatic speed_sample_t random_sample(logic signed [15:0] setpoint);
    speed_sample_t s;
    if ($urandom_range(7, 0) == 0)
      s.measured_speed = 16'($urandom);
    else
      s.measured_speed = 16'(int'(setpoint) + int'($urandom_range(600, 0)) - 300);
    if ($urandom_range(3, 0) == 0)
      s.line_position = 8'($urandom);
    else
      s.line_position = 8'($urandom_range(LINE_HIGH + 7, LINE_LOW - 7));
    s.stop_request = ($urandom_range(3, 0) == 0);
    s.steer_offset = 14'($urandom);
    return s;
  endfunction

  function automatic cfg_t phase_setting(int phase);
    cfg_t c;
    if (phase == 0) begin
      c.speed_setpoint  = 16'sd500;
      c.gain_p          = 16'sd384;
      c.gain_i          = 16'sd64;
      c.gain_d          = -16'sd96;
      c.integral_cutoff = 17'sd200;
    end else if (phase == 1) begin
      c.speed_setpoint  = 16'sh7FFF;
      c.gain_p          = 16'sh7FFF;
      c.gain_i          = 16'sh7FFF;
      c.gain_d          = 16'sh7FFF;
      c.integral_cutoff = 17'sh0FFFF;
    end else if (phase == 2) begin
      c.speed_setpoint  = 16'sh8000;
      c.gain_p          = 16'sh8000;
      c.gain_i          = 16'sh8000;
      c.gain_d          = 16'sh8000;
      c.integral_cutoff = 17'sh10000;
    end else begin
      c.speed_setpoint  = 16'(int'($urandom_range(4000, 0)) - 2000);
      c.gain_p          = 16'(int'($urandom_range(6000, 0)) - 1000);
      c.gain_i          = 16'(int'($urandom_range(1000, 0)) - 500);
      c.gain_d          = 16'(int'($urandom_range(1600, 0)) - 800);
      c.integral_cutoff = 17'(int'($urandom_range(6000, 0)) - 3000);
    end
    return c;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i > 0) begin
        if ($urandom_range(59, 0) == 0)
          drain();
        else
          sender_gap();
      end
      send_sample(random_sample(sb.cfg.speed_setpoint));
    end
  endtask

  initial begin
    sample_ch.valid          = 1'b0;
    sample_ch.measured_speed = '0;
    sample_ch.line_position  = '0;
    sample_ch.stop_request   = 1'b0;
    sample_ch.steer_offset   = '0;
    result_ch.ready          = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed transactions under the reset configuration.
    // Zero error from reset gives zero drive on every duty.
    send_sample(make_sample(0, LINE_CENTER, 0, 0));
    // Just outside the deadband, steering beyond the limit on both sides.
    send_sample(make_sample(0, LINE_HIGH + 1, 0, 8191));
    send_sample(make_sample(0, LINE_LOW - 1, 0, -8192));
    // On the deadband edges the offset is dropped.
    send_sample(make_sample(0, LINE_LOW, 0, 5000));
    send_sample(make_sample(0, LINE_HIGH, 0, -5000));
    // A stop request drops the offset far off center; without one the far edge steers both ways.
    send_sample(make_sample(0, 0, 1, 7000));
    sender_gap();
    send_sample(make_sample(0, 255, 0, 7000));
    send_sample(make_sample(0, 255, 0, -7000));
    // Speed extremes drive the raw output into saturation both ways.
    send_sample(make_sample(32767, 200, 0, 3000));
    send_sample(make_sample(-32768, 10, 0, -3000));
    sender_gap();
    send_sample(make_sample(-32768, 128, 1, -7000));
    send_sample(make_sample(0, 0, 0, 1));
    send_sample(make_sample(100, 128, 0, -1));
    send_sample(make_sample(-100, 30, 0, 4000));
    send_sample(make_sample(0, LINE_CENTER, 1, -8192));

    // Random phases, each under its own configuration.
    for (int phase = 0; phase < PHASES; phase++) begin
      apply_settings(phase_setting(phase));
      run_random(PHASE_ITEMS);
    end
    drain();

    if (sb.failures == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
rtl/ipdd_pkg.sv
rtl/ipdd_if.sv
rtl/ipdd_pid_core.sv
rtl/ipdd_drive_mix.sv
rtl/incremental_pid_differential_drive.sv
bench/drive_scoreboard_pkg.sv
bench/incremental_pid_differential_drive_tb.sv
